/* rtl/positional_list_store_top_macros.svh */
// Assertion macros shared by the positional list store checker.
`ifndef POSITIONAL_LIST_STORE_TOP_MACROS_SVH
`define POSITIONAL_LIST_STORE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional list store check failed");

// Next-cycle implication, disabled while reset is held.
`define PLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional list store check failed");

`endif

/* rtl/pls_pkg.sv */
// Types and codes shared by the positional list store modules.
`default_nettype none
package pls_pkg;

  // Request kinds carried in the action field
  typedef enum logic [3:0] {
    ACT_ADD_FRONT = 4'd0,
    ACT_ADD_END   = 4'd1,
    ACT_INS_AFTER = 4'd2,
    ACT_RM_FRONT  = 4'd3,
    ACT_RM_END    = 4'd4,
    ACT_RM_AT     = 4'd5,
    ACT_FIRST     = 4'd6,
    ACT_LAST      = 4'd7,
    ACT_READ_AT   = 4'd8
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // What every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  localparam int unsigned ValueW  = 32;

endpackage
`default_nettype wire

/* rtl/pls_cell.sv */
// One storage cell of the shifting list chain.
`default_nettype none
module pls_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  wire logic                          clk,
  input  wire pls_pkg::cell_op_t             kind,
  input  wire logic [IW-1:0]                 at,
  input  wire logic [pls_pkg::ValueW-1:0]    wr_value,
  input  wire logic [pls_pkg::ValueW-1:0]    left_q,
  input  wire logic [pls_pkg::ValueW-1:0]    right_q,
  output logic      [pls_pkg::ValueW-1:0]    q
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [pls_pkg::ValueW-1:0] val_r;
  logic [pls_pkg::ValueW-1:0] val_nxt;

  // insert: cells past the gap take from the left, the gap loads the value;
  // delete: cells from the gap on take from the right
  always_comb begin
    val_nxt = val_r;
    case (kind)
      pls_pkg::CELL_INS: begin
        if (MyIdx > at) begin
          val_nxt = left_q;
        end else if (MyIdx == at) begin
          val_nxt = wr_value;
        end
      end
      pls_pkg::CELL_DEL: begin
        if (MyIdx >= at) begin
          val_nxt = right_q;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule
`default_nettype wire

/* rtl/positional_list_store_top.sv */
// Positional list store: ordered list of signed words held in a shifting cell chain.
// One request is accepted per cycle whenever the output register is empty or its
// beat is being taken in the same cycle; the result beat appears in the cycle after
// acceptance. Every insert or removal moves all cells of the chain at once. Read of
// the last or a positioned element passes through a DEPTH-wide selector onto the
// output register, which sets the clock path.
`default_nettype none
module positional_list_store_top #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // action [3:0], value [35:4], position [39:36]
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // read_value [31:0], entry_count [36:32], status [38:37], zero [39]
  output logic [39:0]      out_tdata
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;
  localparam int VW = pls_pkg::ValueW;

  // input beat fields
  pls_pkg::action_t       in_action;
  logic [VW-1:0]          in_value;
  logic [3:0]             in_pos;
  assign in_action = pls_pkg::action_t'(in_tdata[3:0]);
  assign in_value  = in_tdata[35:4];
  assign in_pos    = in_tdata[39:36];

  logic                   out_valid_r;
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          cnt_nxt;
  logic [VW-1:0]          rd_r;
  logic [4:0]             cnt_out_r;
  pls_pkg::status_t       st_r;

  logic                   accept;
  logic                   full;
  logic                   empty;
  logic [PW-1:0]          cnt_x;
  logic [PW-1:0]          pos_x;
  logic                   pos_bad;
  pls_pkg::status_t       st;
  pls_pkg::cell_op_t      kind;
  logic [IW-1:0]          at;
  logic [IW-1:0]          rd_idx;
  logic                   do_rd;
  logic [VW-1:0]          rd_mux;
  logic [VW-1:0]          rd_val;
  logic [PW-1:0]          cnt_nxt_x;

  logic [VW-1:0]          cell_q [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign cnt_x   = PW'(cnt_r);
  assign pos_x   = PW'(in_pos);
  assign pos_bad = pos_x >= cnt_x;

  // request decode: status, chain operation and read index
  always_comb begin
    st      = pls_pkg::ST_OK;
    kind    = pls_pkg::CELL_HOLD;
    at      = '0;
    rd_idx  = '0;
    do_rd   = 1'b0;
    cnt_nxt = cnt_r;
    case (in_action)
      pls_pkg::ACT_ADD_FRONT: begin
        if (full) begin
          st = pls_pkg::ST_FULL;
        end else begin
          kind    = pls_pkg::CELL_INS;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      pls_pkg::ACT_ADD_END: begin
        if (full) begin
          st = pls_pkg::ST_FULL;
        end else begin
          kind    = pls_pkg::CELL_INS;
          at      = IW'(cnt_r);
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      pls_pkg::ACT_INS_AFTER: begin
        if (empty) begin
          kind    = pls_pkg::CELL_INS;
          cnt_nxt = cnt_r + 1'b1;
        end else if (full) begin
          st = pls_pkg::ST_FULL;
        end else if (pos_bad) begin
          st = pls_pkg::ST_BADPOS;
        end else begin
          kind    = pls_pkg::CELL_INS;
          at      = IW'(pos_x + 1'b1);
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      pls_pkg::ACT_RM_FRONT: begin
        if (empty) begin
          st = pls_pkg::ST_EMPTY;
        end else begin
          kind    = pls_pkg::CELL_DEL;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      pls_pkg::ACT_RM_END: begin
        if (empty) begin
          st = pls_pkg::ST_EMPTY;
        end else begin
          kind    = pls_pkg::CELL_DEL;
          at      = IW'(cnt_r - 1'b1);
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      pls_pkg::ACT_RM_AT: begin
        if (empty) begin
          st = pls_pkg::ST_EMPTY;
        end else if (pos_bad) begin
          st = pls_pkg::ST_BADPOS;
        end else begin
          kind    = pls_pkg::CELL_DEL;
          at      = IW'(pos_x);
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      pls_pkg::ACT_FIRST: begin
        if (empty) begin
          st = pls_pkg::ST_EMPTY;
        end else begin
          do_rd = 1'b1;
        end
      end
      pls_pkg::ACT_LAST: begin
        if (empty) begin
          st = pls_pkg::ST_EMPTY;
        end else begin
          do_rd  = 1'b1;
          rd_idx = IW'(cnt_r - 1'b1);
        end
      end
      pls_pkg::ACT_READ_AT: begin
        if (empty) begin
          st = pls_pkg::ST_EMPTY;
        end else if (pos_bad) begin
          st = pls_pkg::ST_BADPOS;
        end else begin
          do_rd  = 1'b1;
          rd_idx = IW'(pos_x);
        end
      end
      default: st = pls_pkg::ST_OK;
    endcase
    if (!accept) begin
      kind = pls_pkg::CELL_HOLD;
    end
  end

  // cell selector for reads
  always_comb begin
    rd_mux = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rd_idx == IW'(i)) begin
        rd_mux = cell_q[i];
      end
    end
  end

  assign rd_val    = do_rd ? rd_mux : '0;
  assign cnt_nxt_x = PW'(cnt_nxt);

  // the cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VW-1:0] left_q;
    logic [VW-1:0] right_q;
    if (g == 0) begin : g_first
      assign left_q = in_value;
    end else begin : g_inner_l
      assign left_q = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_q = cell_q[g];
    end else begin : g_inner_r
      assign right_q = cell_q[g+1];
    end
    pls_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .kind     (kind),
      .at       (at),
      .wr_value (in_value),
      .left_q   (left_q),
      .right_q  (right_q),
      .q        (cell_q[g])
    );
  end

  // control state: output beat valid and element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r      <= rd_val;
      cnt_out_r <= cnt_nxt_x[4:0];
      st_r      <= st;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, st_r, cnt_out_r, rd_r};

endmodule
`default_nettype wire

/* rtl/pls_chk.sv */
// Port-level checker for the positional list store, bound to the top level.
`default_nettype none
`include "positional_list_store_top_macros.svh"
module pls_chk #(
  parameter int DEPTH = 16
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  localparam logic [4:0] FullCnt = 5'(DEPTH);

  logic [1:0] st;
  assign st = out_tdata[38:37];

  // a stalled result beat holds its payload
  `PLS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

  // a dropped add reports a full list
  `PLS_ASSERT_NOW(a_full_cnt, clk, rst_n, out_tvalid && st == pls_pkg::ST_FULL,
                  out_tdata[36:32] == FullCnt)

  // an empty report leaves no elements
  `PLS_ASSERT_NOW(a_empty_cnt, clk, rst_n, out_tvalid && st == pls_pkg::ST_EMPTY,
                  out_tdata[36:32] == 5'd0)

  // errors never carry a read value
  `PLS_ASSERT_NOW(a_err_zero, clk, rst_n, out_tvalid && st != pls_pkg::ST_OK,
                  out_tdata[31:0] == 32'd0)

  // a request waits while the output register is stuck
  `PLS_ASSERT_NOW(a_in_block, clk, rst_n, out_tvalid && !out_tready, !in_tready)

endmodule

bind positional_list_store_top pls_chk #(.DEPTH(DEPTH)) u_pls_chk (.*);
`default_nettype wire

/* dv/tb_positional_list_store_top.sv */
// Self-checking stream testbench for the positional list store, with its own list predictor.
`default_nettype none
module tb_positional_list_store_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ListDepth  = 16;
  localparam int ItemTarget = 1300;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 80;
  localparam int PrintCap   = 50;
  // highest action code, outside the decoded set
  localparam logic [3:0] ActSpare = 4'd15;

  typedef struct {
    logic [3:0]         action;
    logic signed [31:0] value;
    logic [3:0]         position;
  } list_req_t;

  typedef struct {
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
    pls_pkg::status_t   status;
  } list_rsp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  // beats waiting to be offered, and results owed by the block
  logic [39:0] pending_reqs[$];
  list_rsp_t   owed_results[$];

  // predictor state: element 0 is the front
  logic signed [31:0] list_cells[ListDepth];
  int                 list_len;

  int total_reqs;
  int reqs_accepted;
  int results_seen;
  int error_count;
  int stall_cycles;
  int status_hits[4];
  bit in_beat_done;
  bit drain_hold;

  positional_list_store_top #(
    .DEPTH(ListDepth)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // reset and known levels on every input from time zero
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void open_gap(int at, logic signed [31:0] v);
    for (int i = list_len; i > at; i--) list_cells[i] = list_cells[i - 1];
    list_cells[at] = v;
    list_len++;
  endfunction

  function automatic void close_gap(int at);
    for (int i = at; i + 1 < list_len; i++) list_cells[i] = list_cells[i + 1];
    list_len--;
  endfunction

  function automatic list_rsp_t apply_list_request(list_req_t req);
    list_rsp_t rsp;
    bit        full;
    bit        empty;
    int        pos;
    full  = list_len >= ListDepth;
    empty = list_len == 0;
    pos   = req.position;
    rsp.read_value = '0;
    rsp.status     = pls_pkg::ST_OK;
    case (req.action)
      pls_pkg::ACT_ADD_FRONT: begin
        if (full) rsp.status = pls_pkg::ST_FULL;
        else open_gap(0, req.value);
      end
      pls_pkg::ACT_ADD_END: begin
        if (full) rsp.status = pls_pkg::ST_FULL;
        else open_gap(list_len, req.value);
      end
      pls_pkg::ACT_INS_AFTER: begin
        // empty list takes the value at the front whatever the position
        if (empty) open_gap(0, req.value);
        else if (full) rsp.status = pls_pkg::ST_FULL;
        else if (pos >= list_len) rsp.status = pls_pkg::ST_BADPOS;
        else open_gap(pos + 1, req.value);
      end
      pls_pkg::ACT_RM_FRONT: begin
        if (empty) rsp.status = pls_pkg::ST_EMPTY;
        else close_gap(0);
      end
      pls_pkg::ACT_RM_END: begin
        if (empty) rsp.status = pls_pkg::ST_EMPTY;
        else close_gap(list_len - 1);
      end
      pls_pkg::ACT_RM_AT: begin
        if (empty) rsp.status = pls_pkg::ST_EMPTY;
        else if (pos >= list_len) rsp.status = pls_pkg::ST_BADPOS;
        else close_gap(pos);
      end
      pls_pkg::ACT_FIRST: begin
        if (empty) rsp.status = pls_pkg::ST_EMPTY;
        else rsp.read_value = list_cells[0];
      end
      pls_pkg::ACT_LAST: begin
        if (empty) rsp.status = pls_pkg::ST_EMPTY;
        else rsp.read_value = list_cells[list_len - 1];
      end
      pls_pkg::ACT_READ_AT: begin
        if (empty) rsp.status = pls_pkg::ST_EMPTY;
        else if (pos >= list_len) rsp.status = pls_pkg::ST_BADPOS;
        else rsp.read_value = list_cells[pos];
      end
      default: begin
        // spare codes leave the list alone
      end
    endcase
    rsp.entry_count = 5'(list_len);
    return rsp;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic void queue_req(logic [3:0] a, logic signed [31:0] v, logic [3:0] p);
    pending_reqs.push_back({p, v, a});
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] pick_action(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll >= 90) return 4'($urandom_range(0, 15));
    if (roll >= 70) return 4'($urandom_range(pls_pkg::ACT_FIRST, pls_pkg::ACT_READ_AT));
    case (mode)
      0: return 4'($urandom_range(pls_pkg::ACT_ADD_FRONT, pls_pkg::ACT_INS_AFTER));
      1: return 4'($urandom_range(pls_pkg::ACT_RM_FRONT, pls_pkg::ACT_RM_AT));
      default: return 4'($urandom_range(pls_pkg::ACT_ADD_FRONT, pls_pkg::ACT_READ_AT));
    endcase
  endfunction

  initial begin
    int mode;
    int burst;
    // requests against an empty list
    queue_req(pls_pkg::ACT_RM_FRONT, $urandom, 4'd0);
    queue_req(pls_pkg::ACT_RM_END, $urandom, 4'd0);
    queue_req(pls_pkg::ACT_RM_AT, $urandom, 4'd0);
    queue_req(pls_pkg::ACT_FIRST, $urandom, 4'd0);
    queue_req(pls_pkg::ACT_LAST, $urandom, 4'd15);
    queue_req(pls_pkg::ACT_READ_AT, $urandom, 4'd0);
    queue_req(ActSpare, $urandom, 4'd15);
    // insert into an empty list lands at the front
    queue_req(pls_pkg::ACT_INS_AFTER, 32'h7fff_ffff, 4'd15);
    queue_req(pls_pkg::ACT_ADD_FRONT, 32'h8000_0000, 4'd0);
    queue_req(pls_pkg::ACT_ADD_END, '1, 4'd0);
    queue_req(pls_pkg::ACT_INS_AFTER, '0, 4'd0);
    // positions at and beyond the count, then reads and removals that empty the list
    queue_req(pls_pkg::ACT_INS_AFTER, 32'h1234_5678, 4'd4);
    queue_req(pls_pkg::ACT_INS_AFTER, 32'h1234_5678, 4'd15);
    queue_req(pls_pkg::ACT_READ_AT, $urandom, 4'd15);
    queue_req(pls_pkg::ACT_RM_AT, $urandom, 4'd4);
    queue_req(pls_pkg::ACT_FIRST, $urandom, 4'd0);
    queue_req(pls_pkg::ACT_LAST, $urandom, 4'd0);
    queue_req(pls_pkg::ACT_READ_AT, $urandom, 4'd3);
    queue_req(pls_pkg::ACT_READ_AT, $urandom, 4'd1);
    queue_req(pls_pkg::ACT_RM_AT, $urandom, 4'd1);
    queue_req(pls_pkg::ACT_RM_FRONT, $urandom, 4'd0);
    queue_req(pls_pkg::ACT_RM_END, $urandom, 4'd0);
    queue_req(pls_pkg::ACT_LAST, $urandom, 4'd0);
    queue_req(pls_pkg::ACT_RM_AT, $urandom, 4'd0);
    queue_req(pls_pkg::ACT_FIRST, $urandom, 4'd0);
    // random bursts that fill, drain and churn the list
    while (pending_reqs.size() < ItemTarget) begin
      mode  = $urandom_range(0, 2);
      burst = $urandom_range(10, 40);
      repeat (burst) begin
        queue_req(pick_action(mode), pick_value(),
                  $urandom_range(0, 1) ? 4'($urandom_range(0, 7)) : 4'($urandom));
      end
    end
    total_reqs = pending_reqs.size();
  end

  // ---------------------------------------------------------------- idling
  // sender lightly / receiver heavily, then swapped, then no idling at all
  function automatic int idle_pct(bit receiver_side);
    int phase;
    phase = (total_reqs == 0) ? 0 : (reqs_accepted * 3) / total_reqs;
    case (phase)
      0: return receiver_side ? 53 : 7;
      1: return receiver_side ? 7 : 53;
      default: return 0;
    endcase
  endfunction

  // long receiver hold-off while the sender keeps offering beats
  initial begin
    drain_hold = 1'b0;
    wait (rst_n);
    wait (total_reqs != 0 && reqs_accepted >= (2 * total_reqs) / 3 + 40);
    @(posedge clk);
    drain_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    drain_hold = 1'b0;
  end

  // drive both handshakes on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_beat_done) begin
        in_beat_done = 1'b0;
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_reqs.pop_front();
        end else begin
          in_tvalid <= 1'b0;
          in_tdata  <= 40'({$urandom, $urandom});
        end
      end
      out_tready <= !drain_hold && ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    error_count++;
    if (error_count <= PrintCap)
      $display("mismatch on %s at result %0d: got %0h, expected %0h",
               what, results_seen, got, want);
  endtask

  // sample both channels on the rising edge; results first, since a result
  // leaving this edge can never belong to the request entering it
  always @(posedge clk) begin : watch_beats
    list_rsp_t want;
    list_req_t req;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, '0);
        end else begin
          want = owed_results.pop_front();
          if (out_tdata[31:0] !== want.read_value)
            report_mismatch("read_value", 40'(out_tdata[31:0]),
                            40'($unsigned(want.read_value)));
          if (out_tdata[36:32] !== want.entry_count)
            report_mismatch("entry_count", 40'(out_tdata[36:32]), 40'(want.entry_count));
          if (out_tdata[38:37] !== want.status)
            report_mismatch("status", 40'(out_tdata[38:37]), 40'(want.status));
          if (out_tdata[39] !== 1'b0)
            report_mismatch("padding bit", 40'(out_tdata[39]), 40'(1'b0));
          status_hits[want.status]++;
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        req.action   = in_tdata[3:0];
        req.value    = in_tdata[35:4];
        req.position = in_tdata[39:36];
        owed_results.push_back(apply_list_request(req));
        reqs_accepted++;
        in_beat_done = 1'b1;
      end
      // watchdog on cycles without any beat
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog expired after %0d idle cycles", stall_cycles);
        $display("tb_positional_list_store_top failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- end of run
  initial begin
    list_len    = 0;
    error_count = 0;
    wait (rst_n);
    wait (total_reqs != 0);
    while (reqs_accepted < total_reqs || owed_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("run covered %0d requests and %0d results", reqs_accepted, results_seen);
    $display("statuses seen: ok %0d, empty %0d, full %0d, bad position %0d",
             status_hits[pls_pkg::ST_OK], status_hits[pls_pkg::ST_EMPTY],
             status_hits[pls_pkg::ST_FULL], status_hits[pls_pkg::ST_BADPOS]);
    if (error_count == 0) begin
      $display("tb_positional_list_store_top passed");
    end else begin
      $display("tb_positional_list_store_top failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
